// ===== rtl/core/cct_pkg.sv =====
// shared constants, codes and command/status types of the cluster chain table
package cct_pkg;

    localparam int DEPTH_DEF    = 4096;
    localparam int END_MARK_DEF = 65535;
    localparam int BAD_MARK_DEF = 65527;

    localparam int VAL_W   = 16;
    localparam int EPOCH_W = 8;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_CHAIN    = 2'd3;

    // read address select
    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_IN   = 2'd1;
    localparam logic [1:0] RD_INC  = 2'd2;
    localparam logic [1:0] RD_LINK = 2'd3;

    // address register update
    localparam logic [1:0] ADDR_HOLD = 2'd0;
    localparam logic [1:0] ADDR_LOAD = 2'd1;
    localparam logic [1:0] ADDR_CLR  = 2'd2;

    // result kinds
    localparam logic [2:0] RES_ALLOC = 3'd0;
    localparam logic [2:0] RES_NONE  = 3'd1;
    localparam logic [2:0] RES_RANGE = 3'd2;
    localparam logic [2:0] RES_OK    = 3'd3;
    localparam logic [2:0] RES_CHAIN = 3'd4;
    localparam logic [2:0] RES_READ  = 3'd5;

    typedef struct packed {
        logic       rd_en;
        logic [1:0] rd_sel;
        logic [1:0] addr_op;
        logic       tbl_wr_zero;
        logic       tbl_wr_in;
        logic       seen_wr_zero;
        logic       seen_wr_epoch;
        logic       epoch_inc;
        logic       epoch_one;
        logic       res_en;
        logic [2:0] res_kind;
    } cct_cmd_t;

    typedef struct packed {
        logic rd_zero;
        logic rd_end;
        logic rd_out;
        logic self_loop;
        logic seen_hit;
        logic addr_last;
        logic cl_out;
        logic epoch_max;
    } cct_stat_t;

endpackage

// ===== rtl/core/cluster_chain_table.sv =====
// cluster chain table top level: controller plus table datapath
//
//  channel   ports                                        handshake
//  request   op, cluster, link_value                      start & !busy
//  result    entry_value, found, entry_free, entry_last,  done, one cycle
//            entry_bad, status
//
// write link and out-of-range requests are answered from idle; read adds the S_READ state
// allocate: reads from entry 0 up to the first empty entry, or the last entry when full,
// one table read per cycle
// free: walks the chain one link per cycle, stopping on a revisited entry when the
// chain loops back; every 255th chain walk adds a clear of the walk marks
// after reset the table is cleared one entry per cycle with busy high
// results cannot be stalled: done is high for exactly one cycle per request
module cluster_chain_table #(
    parameter int DEPTH    = cct_pkg::DEPTH_DEF,
    parameter int END_MARK = cct_pkg::END_MARK_DEF,
    parameter int BAD_MARK = cct_pkg::BAD_MARK_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 op,
    input  logic [cct_pkg::VAL_W-1:0]  cluster,
    input  logic [cct_pkg::VAL_W-1:0]  link_value,
    output logic                       done,
    output logic [cct_pkg::VAL_W-1:0]  entry_value,
    output logic                       found,
    output logic                       entry_free,
    output logic                       entry_last,
    output logic                       entry_bad,
    output logic [1:0]                 status
);
    import cct_pkg::*;

    cct_cmd_t  cmd;
    cct_stat_t stat;

    cct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    cct_datapath #(
        .DEPTH    (DEPTH),
        .END_MARK (END_MARK),
        .BAD_MARK (BAD_MARK)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cluster     (cluster),
        .link_value  (link_value),
        .done        (done),
        .entry_value (entry_value),
        .found       (found),
        .entry_free  (entry_free),
        .entry_last  (entry_last),
        .entry_bad   (entry_bad),
        .status      (status)
    );

endmodule

// ===== rtl/core/cct_datapath.sv =====
// link table and walk-mark memories, address and epoch registers, result registers
module cct_datapath #(
    parameter int DEPTH    = cct_pkg::DEPTH_DEF,
    parameter int END_MARK = cct_pkg::END_MARK_DEF,
    parameter int BAD_MARK = cct_pkg::BAD_MARK_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cct_pkg::cct_cmd_t          cmd,
    output cct_pkg::cct_stat_t         stat,
    input  logic [cct_pkg::VAL_W-1:0]  cluster,
    input  logic [cct_pkg::VAL_W-1:0]  link_value,
    output logic                       done,
    output logic [cct_pkg::VAL_W-1:0]  entry_value,
    output logic                       found,
    output logic                       entry_free,
    output logic                       entry_last,
    output logic                       entry_bad,
    output logic [1:0]                 status
);
    import cct_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [VAL_W-1:0]   link_mem [DEPTH];
    logic [EPOCH_W-1:0] seen_mem [DEPTH];

    logic [VAL_W-1:0]   tbl_rdata_reg;
    logic [EPOCH_W-1:0] seen_rdata_reg;

    logic [AW-1:0]      addr_reg, addr_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               done_reg;

    logic [VAL_W-1:0]   entry_value_reg;
    logic               found_reg, entry_free_reg, entry_last_reg, entry_bad_reg;
    logic [1:0]         status_reg;

    logic [VAL_W-1:0]   entry_value_next;
    logic               found_next, entry_free_next, entry_last_next, entry_bad_next;
    logic [1:0]         status_next;

    logic [AW-1:0]      raddr;
    logic [AW-1:0]      addr_inc;
    logic               tbl_we;
    logic [AW-1:0]      tbl_waddr;
    logic [VAL_W-1:0]   tbl_wdata;
    logic               seen_we;
    logic [EPOCH_W-1:0] seen_wdata;

    assign addr_inc = addr_reg + AW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: raddr = '0;
            RD_IN:   raddr = cluster[AW-1:0];
            RD_INC:  raddr = addr_inc;
            RD_LINK: raddr = tbl_rdata_reg[AW-1:0];
            default: raddr = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.addr_op)
            ADDR_LOAD: addr_next = raddr;
            ADDR_CLR:  addr_next = '0;
            default:   addr_next = addr_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.epoch_one)
        begin
            epoch_next = EPOCH_W'(1);
        end
        else if (cmd.epoch_inc)
        begin
            epoch_next = epoch_reg + EPOCH_W'(1);
        end
        else
        begin
            epoch_next = epoch_reg;
        end
    end

    // single write port: link writes come from the request, the rest clear at addr_reg
    assign tbl_we     = cmd.tbl_wr_zero | cmd.tbl_wr_in;
    assign tbl_waddr  = cmd.tbl_wr_in ? cluster[AW-1:0] : addr_reg;
    assign tbl_wdata  = cmd.tbl_wr_in ? link_value : '0;
    assign seen_we    = cmd.seen_wr_zero | cmd.seen_wr_epoch;
    assign seen_wdata = cmd.seen_wr_epoch ? epoch_reg : '0;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            link_mem[tbl_waddr] <= tbl_wdata;
        end
        if (cmd.rd_en)
        begin
            tbl_rdata_reg <= link_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[addr_reg] <= seen_wdata;
        end
        if (cmd.rd_en)
        begin
            seen_rdata_reg <= seen_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            epoch_reg <= EPOCH_W'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            addr_reg  <= addr_next;
            epoch_reg <= epoch_next;
            done_reg  <= cmd.res_en;
        end
    end

    always_comb
    begin
        entry_value_next = '0;
        found_next       = 1'b0;
        entry_free_next  = 1'b0;
        entry_last_next  = 1'b0;
        entry_bad_next   = 1'b0;
        status_next      = ST_OK;
        case (cmd.res_kind)
            RES_ALLOC:
            begin
                entry_value_next = VAL_W'(addr_reg);
                found_next       = 1'b1;
            end
            RES_NONE:  status_next = ST_NONE;
            RES_RANGE: status_next = ST_RANGE;
            RES_CHAIN: status_next = ST_CHAIN;
            RES_READ:
            begin
                entry_value_next = tbl_rdata_reg;
                entry_free_next  = stat.rd_zero;
                entry_last_next  = stat.rd_end;
                entry_bad_next   = (tbl_rdata_reg == VAL_W'(BAD_MARK));
            end
            default: status_next = ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_en)
        begin
            entry_value_reg <= entry_value_next;
            found_reg       <= found_next;
            entry_free_reg  <= entry_free_next;
            entry_last_reg  <= entry_last_next;
            entry_bad_reg   <= entry_bad_next;
            status_reg      <= status_next;
        end
    end

    assign stat.rd_zero   = (tbl_rdata_reg == '0);
    assign stat.rd_end    = (tbl_rdata_reg == VAL_W'(END_MARK));
    assign stat.rd_out    = (tbl_rdata_reg >= VAL_W'(DEPTH));
    assign stat.self_loop = (tbl_rdata_reg == VAL_W'(addr_reg));
    assign stat.seen_hit  = (seen_rdata_reg == epoch_reg);
    assign stat.addr_last = (addr_reg == AW'(DEPTH - 1));
    assign stat.cl_out    = (cluster >= VAL_W'(DEPTH));
    assign stat.epoch_max = (epoch_reg == '1);

    assign done        = done_reg;
    assign entry_value = entry_value_reg;
    assign found       = found_reg;
    assign entry_free  = entry_free_reg;
    assign entry_last  = entry_last_reg;
    assign entry_bad   = entry_bad_reg;
    assign status      = status_reg;

endmodule

// ===== rtl/core/cct_ctrl.sv =====
// controller: sweeps, allocate scan, chain walk and request sequencing
module cct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          op,
    input  cct_pkg::cct_stat_t  stat,
    output cct_pkg::cct_cmd_t   cmd,
    output logic                busy
);
    import cct_pkg::*;

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       sweep_all_reg, sweep_all_next;
    logic       walk_end;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        sweep_all_next = sweep_all_reg;
        walk_end       = 1'b0;

        case (state_reg)
            S_SWEEP:
            begin
                cmd.tbl_wr_zero  = sweep_all_reg;
                cmd.seen_wr_zero = 1'b1;
                cmd.rd_sel       = RD_INC;
                cmd.addr_op      = ADDR_LOAD;
                if (stat.addr_last)
                begin
                    cmd.epoch_one = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_ALLOC)
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_ZERO;
                        cmd.addr_op = ADDR_LOAD;
                        state_next  = S_SCAN;
                    end
                    else if (stat.cl_out)
                    begin
                        cmd.res_en   = 1'b1;
                        cmd.res_kind = RES_RANGE;
                    end
                    else if (op == OP_WRITE)
                    begin
                        cmd.tbl_wr_in = 1'b1;
                        cmd.res_en    = 1'b1;
                        cmd.res_kind  = RES_OK;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_IN;
                        cmd.addr_op = ADDR_LOAD;
                        state_next  = (op == OP_READ) ? S_READ : S_WALK;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.rd_zero)
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_kind = RES_ALLOC;
                    state_next   = S_IDLE;
                end
                else if (stat.addr_last)
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_kind = RES_NONE;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_INC;
                    cmd.addr_op = ADDR_LOAD;
                end
            end
            S_READ:
            begin
                cmd.res_en   = 1'b1;
                cmd.res_kind = RES_READ;
                state_next   = S_IDLE;
            end
            S_WALK:
            begin
                cmd.res_en = 1'b1;
                if (stat.seen_hit)
                begin
                    // landed on an entry this walk already emptied
                    cmd.res_kind = RES_CHAIN;
                    walk_end     = 1'b1;
                end
                else
                begin
                    cmd.tbl_wr_zero   = 1'b1;
                    cmd.seen_wr_epoch = 1'b1;
                    if (stat.rd_zero || stat.rd_end)
                    begin
                        cmd.res_kind = RES_OK;
                        walk_end     = 1'b1;
                    end
                    else if (stat.rd_out || stat.self_loop)
                    begin
                        cmd.res_kind = RES_CHAIN;
                        walk_end     = 1'b1;
                    end
                    else
                    begin
                        cmd.res_en  = 1'b0;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_LINK;
                        cmd.addr_op = ADDR_LOAD;
                    end
                end
                if (walk_end)
                begin
                    // each walk gets a fresh epoch; wrap forces a clear of the marks
                    if (stat.epoch_max)
                    begin
                        cmd.addr_op    = ADDR_CLR;
                        sweep_all_next = 1'b0;
                        state_next     = S_SWEEP;
                    end
                    else
                    begin
                        cmd.epoch_inc = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_all_reg <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_all_reg <= sweep_all_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== tb/testbench.sv =====
// testbench for the cluster chain table: directed rows, a long chain pass and random chain traffic
`timescale 1ns / 1ps

module testbench;
    import cct_pkg::*;

    localparam int DEPTH          = cct_pkg::DEPTH_DEF;
    localparam int FILL_LEN       = 256;
    localparam int RANDOM_ITEMS   = 1160;
    localparam int WINDOW         = 48;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam logic [15:0] END_V     = 16'(cct_pkg::END_MARK_DEF);
    localparam logic [15:0] BAD_V     = 16'(cct_pkg::BAD_MARK_DEF);
    localparam logic [15:0] TOP_IDX   = 16'(DEPTH - 1);
    localparam logic [15:0] FIRST_OUT = 16'(DEPTH);
    localparam logic [15:0] FILL_TOP  = 16'(FILL_LEN - 1);

    typedef struct packed {
        logic [15:0] value;
        logic        found;
        logic        is_free;
        logic        is_last;
        logic        is_bad;
        logic [1:0]  status;
    } table_result_t;

    typedef struct packed {
        logic [1:0]    op;
        logic [15:0]   cluster;
        logic [15:0]   link;
        logic          typed;
        table_result_t want;
    } directed_row_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [1:0]  op         = OP_ALLOC;
    logic [15:0] cluster    = 16'd0;
    logic [15:0] link_value = 16'd0;
    logic        busy;
    logic        done;
    logic [15:0] entry_value;
    logic        found;
    logic        entry_free;
    logic        entry_last;
    logic        entry_bad;
    logic [1:0]  status;

    logic [15:0]   shadow_links [DEPTH];
    table_result_t pending_results [$];
    directed_row_t directed_rows [$];
    int            errors = 0;
    int            idle_pct = 0;
    int            quiet_cycles = 0;
    int            op_count [4];
    int            status_count [4];

    cluster_chain_table DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .cluster     (cluster),
        .link_value  (link_value),
        .done        (done),
        .entry_value (entry_value),
        .found       (found),
        .entry_free  (entry_free),
        .entry_last  (entry_last),
        .entry_bad   (entry_bad),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // shadow of the link table; updates it and returns the expected result
    task automatic apply_table_op(input logic [1:0] opc, input logic [15:0] cl,
                                  input logic [15:0] lv, output table_result_t r);
        int cur;
        int nxt;
        bit visited [int];
        bit walking;
        r = '0;
        if (opc == OP_ALLOC)
        begin
            r.status = ST_NONE;
            for (int i = 0; i < DEPTH && !r.found; i++)
            begin
                if (shadow_links[i] == 16'd0)
                begin
                    r.value  = i[15:0];
                    r.found  = 1'b1;
                    r.status = ST_OK;
                end
            end
        end
        else if (cl >= DEPTH)
        begin
            r.status = ST_RANGE;
        end
        else if (opc == OP_FREE)
        begin
            cur = cl;
            visited[cur] = 1'b1;
            walking = 1'b1;
            while (walking)
            begin
                nxt = shadow_links[cur];
                shadow_links[cur] = 16'd0;
                if (nxt == 0 || nxt == END_V)
                begin
                    walking = 1'b0;
                end
                // link outside the table or back onto this walk
                else if (nxt >= DEPTH || visited.exists(nxt))
                begin
                    r.status = ST_CHAIN;
                    walking = 1'b0;
                end
                else
                begin
                    visited[nxt] = 1'b1;
                    cur = nxt;
                end
            end
        end
        else if (opc == OP_WRITE)
        begin
            shadow_links[cl] = lv;
        end
        else
        begin
            r.value   = shadow_links[cl];
            r.is_free = (shadow_links[cl] == 16'd0);
            r.is_last = (shadow_links[cl] == END_V);
            r.is_bad  = (shadow_links[cl] == BAD_V);
        end
    endtask

    function void dir_row(input logic [1:0] opc, input logic [15:0] cl, input logic [15:0] lv,
                          input logic typed, input logic [15:0] v, input logic fnd,
                          input logic fr, input logic la, input logic bd,
                          input logic [1:0] st);
        directed_row_t row;
        row.op      = opc;
        row.cluster = cl;
        row.link    = lv;
        row.typed   = typed;
        row.want    = '{v, fnd, fr, la, bd, st};
        directed_rows.push_back(row);
    endfunction

    // drives one request after a random gap and records what it should return
    task automatic issue_request(input logic [1:0] opc, input logic [15:0] cl,
                                 input logic [15:0] lv, input logic typed,
                                 input table_result_t want);
        table_result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        op         <= opc;
        cluster    <= cl;
        link_value <= lv;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_table_op(opc, cl, lv, predicted);
        pending_results.push_back(typed ? want : predicted);
        op_count[opc]++;
    endtask

    function automatic logic [15:0] pick_slot();
        if ($urandom_range(15) == 0)
            return 16'($urandom_range(DEPTH - 1));
        return 16'($urandom_range(WINDOW - 1));
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
        end
    endtask

    // result checker and watchdog
    always @(posedge clk)
    begin
        table_result_t w;
        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (rst_n && done)
        begin
            status_count[status]++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request waiting, value %0h status %0d",
                         $time, entry_value, status);
            end
            else
            begin
                w = pending_results.pop_front();
                check_field("entry_value", w.value, entry_value);
                check_field("found", 16'(w.found), 16'(found));
                check_field("entry_free", 16'(w.is_free), 16'(entry_free));
                check_field("entry_last", 16'(w.is_last), 16'(entry_last));
                check_field("entry_bad", 16'(w.is_bad), 16'(entry_bad));
                check_field("status", 16'(w.status), 16'(status));
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int nodes [6];
        int len;
        int kind;
        int sel;
        int random_sent;
        int idle_by_phase [3];
        logic [1:0]  opc;
        logic [15:0] term;
        idle_by_phase = '{0, 55, 13};
        random_sent = 0;
        for (int i = 0; i < DEPTH; i++)
            shadow_links[i] = 16'd0;
        for (int i = 0; i < 4; i++)
        begin
            op_count[i] = 0;
            status_count[i] = 0;
        end

        // directed requests; typed rows carry their own expectation
        dir_row(OP_READ,  16'd0,     16'd0,     1, 16'd0, 0, 1, 0, 0, ST_OK);
        dir_row(OP_READ,  TOP_IDX,   16'd0,     1, 16'd0, 0, 1, 0, 0, ST_OK);
        dir_row(OP_READ,  16'hFFFF,  16'hFFFF,  1, 16'd0, 0, 0, 0, 0, ST_RANGE);
        dir_row(OP_WRITE, FIRST_OUT, 16'hFFFF,  1, 16'd0, 0, 0, 0, 0, ST_RANGE);
        dir_row(OP_FREE,  FIRST_OUT, 16'd0,     1, 16'd0, 0, 0, 0, 0, ST_RANGE);
        dir_row(OP_ALLOC, 16'hFFFF,  16'hFFFF,  1, 16'd0, 1, 0, 0, 0, ST_OK);
        dir_row(OP_WRITE, 16'd0,     END_V,     1, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_READ,  16'd0,     16'd0,     1, END_V, 0, 0, 1, 0, ST_OK);
        dir_row(OP_ALLOC, 16'd0,     16'd0,     1, 16'd1, 1, 0, 0, 0, ST_OK);
        dir_row(OP_WRITE, 16'd1,     BAD_V,     1, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_READ,  16'd1,     16'd0,     1, BAD_V, 0, 0, 0, 1, ST_OK);
        // bad cluster mark counts as a link outside the table
        dir_row(OP_FREE,  16'd1,     16'd0,     1, 16'd0, 0, 0, 0, 0, ST_CHAIN);
        dir_row(OP_READ,  16'd1,     16'd0,     1, 16'd0, 0, 1, 0, 0, ST_OK);
        dir_row(OP_WRITE, 16'd2,     FIRST_OUT, 1, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_FREE,  16'd2,     16'd0,     1, 16'd0, 0, 0, 0, 0, ST_CHAIN);
        // two-entry loop, then a self loop
        dir_row(OP_WRITE, 16'd3,     16'd4,     0, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_WRITE, 16'd4,     16'd3,     0, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_FREE,  16'd3,     16'd0,     1, 16'd0, 0, 0, 0, 0, ST_CHAIN);
        dir_row(OP_READ,  16'd4,     16'd0,     0, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_WRITE, 16'd5,     16'd5,     0, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_FREE,  16'd5,     16'd0,     1, 16'd0, 0, 0, 0, 0, ST_CHAIN);
        dir_row(OP_WRITE, 16'd6,     16'd7,     0, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_WRITE, 16'd7,     END_V,     0, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_FREE,  16'd6,     16'd0,     1, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_READ,  16'd7,     16'd0,     0, 16'd0, 0, 0, 0, 0, ST_OK);
        dir_row(OP_FREE,  16'd0,     16'd0,     1, 16'd0, 0, 0, 0, 0, ST_OK);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue_request(directed_rows[i].op, directed_rows[i].cluster, directed_rows[i].link,
                          directed_rows[i].typed, directed_rows[i].want);

        // fill the low part of the table with one long chain, then walk it back to empty
        idle_pct = 5;
        for (int i = 0; i < FILL_LEN - 1; i++)
            issue_request(OP_WRITE, i[15:0], 16'(i + 1), 0, '0);
        issue_request(OP_WRITE, FILL_TOP, END_V, 0, '0);
        issue_request(OP_ALLOC, 16'd0, 16'd0, 0, '0);
        issue_request(OP_READ, FILL_TOP, 16'd0, 0, '0);
        issue_request(OP_FREE, 16'd0, 16'd0, 0, '0);
        issue_request(OP_ALLOC, 16'd0, 16'd0, 0, '0);

        while (random_sent < RANDOM_ITEMS)
        begin
            idle_pct = idle_by_phase[(random_sent * 3) / RANDOM_ITEMS];
            sel = $urandom_range(99);
            if (sel < 40)
            begin
                // build a short chain with a random ending, maybe read it, then usually free it
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++)
                    nodes[i] = pick_slot();
                kind = $urandom_range(5);
                case (kind)
                    1: term = 16'd0;
                    2: term = BAD_V;
                    3: term = 16'($urandom_range(65535, DEPTH));
                    4: term = 16'(nodes[$urandom_range(len - 1)]);
                    default: term = END_V;
                endcase
                for (int i = 0; i < len; i++)
                    issue_request(OP_WRITE, 16'(nodes[i]),
                                  (i == len - 1) ? term : 16'(nodes[i + 1]), 0, '0);
                if ($urandom_range(1))
                    issue_request(OP_READ, 16'(nodes[$urandom_range(len - 1)]), 16'($urandom),
                                  0, '0);
                if ($urandom_range(7) != 0)
                    issue_request(OP_FREE, 16'(nodes[0]), 16'($urandom), 0, '0);
                random_sent += len + 2;
            end
            else
            begin
                if (sel < 55)
                    issue_request(OP_ALLOC, 16'($urandom), 16'($urandom), 0, '0);
                else if (sel < 67)
                    issue_request(OP_READ, pick_slot(), 16'($urandom), 0, '0);
                else if (sel < 79)
                    issue_request(OP_WRITE, pick_slot(),
                                  $urandom_range(1) ? 16'($urandom) : pick_slot(), 0, '0);
                else if (sel < 87)
                    issue_request(OP_FREE, pick_slot(), 16'($urandom), 0, '0);
                else if (sel < 97)
                begin
                    opc = 2'($urandom_range(3, 1));
                    issue_request(opc, 16'($urandom_range(65535, DEPTH)), 16'($urandom), 0, '0);
                end
                else
                begin
                    opc = 2'($urandom_range(3, 1));
                    issue_request(opc, $urandom_range(1) ? TOP_IDX : 16'd0,
                                  $urandom_range(1) ? END_V : 16'd0, 0, '0);
                end
                random_sent++;
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("covered %0d requests: %0d allocate, %0d free, %0d write, %0d read",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_WRITE], op_count[OP_READ]);
        $display("results by status: ok %0d, none free %0d, out of range %0d, chain error %0d",
                 status_count[ST_OK], status_count[ST_NONE], status_count[ST_RANGE],
                 status_count[ST_CHAIN]);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cct_pkg.sv
rtl/core/cct_datapath.sv
rtl/core/cct_ctrl.sv
rtl/core/cluster_chain_table.sv
tb/testbench.sv
